// ----- hw/rtl/skf_pkg.sv -----
// Shared types and constants for the scalar Kalman filter.
package skf_pkg;

	localparam int ADDR_W = 4;

	// Register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_PROCESS_NOISE     = 2'd0;
	localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
	localparam logic [1:0] REG_INITIAL_ESTIMATE  = 2'd2;
	localparam logic [1:0] REG_USE_INITIAL       = 2'd3;

	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PREP_A = 7'b0000010,
		ST_PREP_B = 7'b0000100,
		ST_DIV    = 7'b0001000,
		ST_GAIN   = 7'b0010000,
		ST_MUL    = 7'b0100000,
		ST_FIN    = 7'b1000000
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic restart;
		logic prep_a;
		logic prep_b;
		logic div_step;
		logic div_first;
		logic gain;
		logic mul_step;
		logic mul_last;
		logic commit;
		logic seed;
	} dp_cmd_t;

	typedef struct packed {
		logic seeded;
	} dp_status_t;

endpackage

// ----- hw/rtl/skf_regs.sv -----
// APB configuration registers of the scalar Kalman filter.
module skf_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [skf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [31:0]                process_noise,
	output logic [31:0]                measurement_noise,
	output logic [31:0]                initial_estimate,
	output logic                       use_initial_estimate
);

	logic [31:0] process_noise_q;
	logic [31:0] measurement_noise_q;
	logic [31:0] initial_estimate_q;
	logic        use_initial_q;
	logic        wr_en;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q     <= 32'd655;
			measurement_noise_q <= 32'd65536;
			initial_estimate_q  <= 32'd0;
			use_initial_q       <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				skf_pkg::REG_PROCESS_NOISE:     process_noise_q     <= pwdata;
				skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise_q <= pwdata;
				skf_pkg::REG_INITIAL_ESTIMATE:  initial_estimate_q  <= pwdata;
				skf_pkg::REG_USE_INITIAL:       use_initial_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			skf_pkg::REG_PROCESS_NOISE:     prdata = process_noise_q;
			skf_pkg::REG_MEASUREMENT_NOISE: prdata = measurement_noise_q;
			skf_pkg::REG_INITIAL_ESTIMATE:  prdata = initial_estimate_q;
			skf_pkg::REG_USE_INITIAL:       prdata = {31'd0, use_initial_q};
			default:                        prdata = 32'd0;
		endcase
	end

	assign process_noise        = process_noise_q;
	assign measurement_noise    = measurement_noise_q;
	assign initial_estimate     = initial_estimate_q;
	assign use_initial_estimate = use_initial_q;

endmodule

// ----- hw/rtl/skf_ctrl.sv -----
// Sequencing state machine of the scalar Kalman filter.
module skf_ctrl #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                op,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  skf_pkg::dp_status_t status,
	output skf_pkg::dp_cmd_t    cmd
);

	localparam int CW = $clog2(FRAC_BITS + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS);

	skf_pkg::ctrl_state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          seed_q;
	logic          out_valid_q;
	logic          accept;
	logic          out_free;

	assign in_stall = (state_q != skf_pkg::ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			skf_pkg::ST_IDLE: begin
				if (accept) begin
					if (op == skf_pkg::OP_RESTART) begin
						cmd.restart = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = status.seeded ? skf_pkg::ST_PREP_A : skf_pkg::ST_FIN;
					end
				end
			end
			skf_pkg::ST_PREP_A: begin
				cmd.prep_a = 1'b1;
				state_d    = skf_pkg::ST_PREP_B;
			end
			skf_pkg::ST_PREP_B: begin
				cmd.prep_b = 1'b1;
				state_d    = skf_pkg::ST_DIV;
			end
			skf_pkg::ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				if (cnt_q == CNT_LAST) state_d = skf_pkg::ST_GAIN;
			end
			skf_pkg::ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d  = skf_pkg::ST_MUL;
			end
			skf_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.mul_last = (cnt_q == CNT_LAST);
				if (cnt_q == CNT_LAST) state_d = skf_pkg::ST_FIN;
			end
			skf_pkg::ST_FIN: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.commit = 1'b1;
					cmd.seed   = seed_q;
					state_d    = skf_pkg::ST_IDLE;
				end
			end
			default: state_d = skf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skf_pkg::ST_IDLE;
			cnt_q       <= '0;
			seed_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) seed_q <= ~status.seeded;
			if ((cmd.div_step || cmd.mul_step) && cnt_q != CNT_LAST) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/skf_datapath.sv -----
// Datapath of the scalar Kalman filter: state, restoring divider and shift-add multipliers.
module skf_datapath #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  skf_pkg::dp_cmd_t    cmd,
	output skf_pkg::dp_status_t status,
	input  logic [31:0]         process_noise,
	input  logic [31:0]         measurement_noise,
	input  logic [31:0]         initial_estimate,
	input  logic                use_initial_estimate,
	input  logic [31:0]         measurement,
	output logic [31:0]         estimate,
	output logic [31:0]         covariance
);

	localparam int DW = DATA_WIDTH;
	localparam int XW = (DW > 32) ? DW : 32;
	localparam int SW = XW + 1;
	localparam int NW = XW + 1;
	localparam int IW = DW + 1;
	localparam int GW = FRAC_BITS + 1;

	localparam logic [DW-1:0] COV_MAX = {DW{1'b1}};
	localparam logic [DW-1:0] COV_ONE =
		(FRAC_BITS >= DW) ? {DW{1'b1}} : (DW'(1) << FRAC_BITS);
	localparam logic [GW-1:0] G_ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [DW-1:0] EST_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] EST_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [XW-1:0] OUT_MAX = XW'(32'hFFFF_FFFF);

	// sign-extend a 32-bit value and clamp it to the data range
	function automatic logic signed [DW-1:0] sat_in(input logic [31:0] v);
		logic signed [SW-1:0] w;
		w = SW'($signed(v));
		if (w > SW'(EST_MAX)) return EST_MAX;
		else if (w < SW'(EST_MIN)) return EST_MIN;
		else return DW'(w);
	endfunction

	logic                 seeded_q;
	logic signed [DW-1:0] est_q;
	logic [DW-1:0]        cov_q;
	logic signed [DW-1:0] m_q;
	logic [DW-1:0]        p1_q;
	logic [IW-1:0]        mag_q;
	logic                 neg_q;
	logic [NW-1:0]        den_q;
	logic [NW-1:0]        rem_q;
	logic [GW-1:0]        quo_q;
	logic [GW-1:0]        g_q;
	logic [GW-1:0]        cg_q;
	logic [IW-1:0]        acc_e_q;
	logic [DW-1:0]        acc_c_q;
	logic [31:0]          estimate_q;
	logic [31:0]          covariance_q;

	logic [NW-1:0]        p1_sum;
	logic [DW-1:0]        p1_sat;
	logic signed [IW-1:0] innov;
	logic [IW-1:0]        innov_mag;
	logic [NW-1:0]        den_sum;
	logic [NW:0]          trial;
	logic [NW:0]          diff;
	logic                 ge;
	logic [GW-1:0]        gain_cl;
	logic [IW:0]          sum_e;
	logic [DW:0]          sum_c;
	logic signed [IW-1:0] delta_s;
	logic signed [IW-1:0] est_upd;
	logic signed [DW-1:0] est_next;
	logic [DW-1:0]        cov_next;

	assign p1_sum    = NW'(cov_q) + NW'(process_noise);
	assign p1_sat    = (p1_sum > NW'(COV_MAX)) ? COV_MAX : DW'(p1_sum);
	assign innov     = IW'(m_q) - IW'(est_q);
	assign innov_mag = innov[IW-1] ? IW'(-innov) : IW'(innov);
	assign den_sum   = NW'(p1_q) + NW'(measurement_noise);

	// one restoring step per cycle; the first step compares without a shift
	assign trial = cmd.div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	// a zero denominator leaves all quotient bits set: clamp to 1.0
	assign gain_cl = (quo_q > G_ONE) ? G_ONE : quo_q;

	// shift-add, multiplier LSB first; the top gain bit adds without a shift
	assign sum_e = {1'b0, acc_e_q} + (g_q[0] ? {1'b0, mag_q} : '0);
	assign sum_c = {1'b0, acc_c_q} + (cg_q[0] ? {1'b0, p1_q} : '0);

	assign delta_s = $signed(acc_e_q);
	assign est_upd = neg_q ? (IW'(est_q) - delta_s) : (IW'(est_q) + delta_s);

	always_comb begin
		if (cmd.seed) begin
			est_next = m_q;
			cov_next = COV_ONE;
		end else begin
			est_next = DW'(est_upd);
			cov_next = acc_c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			est_q    <= '0;
			cov_q    <= COV_ONE;
		end else if (cmd.restart) begin
			seeded_q <= use_initial_estimate;
			est_q    <= sat_in(initial_estimate);
			cov_q    <= COV_ONE;
		end else if (cmd.commit) begin
			seeded_q <= 1'b1;
			est_q    <= est_next;
			cov_q    <= cov_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) m_q <= sat_in(measurement);
		if (cmd.prep_a) begin
			p1_q  <= p1_sat;
			mag_q <= innov_mag;
			neg_q <= innov[IW-1];
		end
		if (cmd.prep_b) begin
			den_q <= den_sum;
			rem_q <= NW'(p1_q);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
			quo_q <= {quo_q[GW-2:0], ge};
		end
		if (cmd.gain) begin
			g_q     <= gain_cl;
			cg_q    <= G_ONE - gain_cl;
			acc_e_q <= '0;
			acc_c_q <= '0;
		end
		if (cmd.mul_step) begin
			g_q     <= g_q >> 1;
			cg_q    <= cg_q >> 1;
			acc_e_q <= cmd.mul_last ? sum_e[IW-1:0] : sum_e[IW:1];
			acc_c_q <= cmd.mul_last ? sum_c[DW-1:0] : sum_c[DW:1];
		end
		if (cmd.commit) begin
			estimate_q   <= 32'(est_next);
			covariance_q <= (XW'(cov_next) > OUT_MAX) ? 32'hFFFF_FFFF : 32'(cov_next);
		end
	end

	assign status.seeded = seeded_q;
	assign estimate      = estimate_q;
	assign covariance    = covariance_q;

endmodule

// ----- hw/rtl/scalar_kalman_filter_top.sv -----
// Top level of the scalar Kalman filter: registers, controller and datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  in       | to block  | in_valid/in_stall  | op, measurement
//  out      | from block| out_valid/out_stall| estimate, covariance
//  config   | to block  | APB psel/penable   | paddr, pwdata, prdata
//
// An update steps through PREP_A, PREP_B, the divider, GAIN, the multiplier and FIN,
// one divider or multiplier bit per cycle; the input frees in the same cycle as the result.
// Seeding: straight to FIN, result and free input together. Restart: no result, input never stalled.
// Reset restores estimate 0, covariance 1.0, not seeded, and the register defaults.
// A finished result waits in the output register under out_stall; the next
// request is taken meanwhile and only its own completion waits for the slot.
module scalar_kalman_filter_top #(
	parameter int FRAC_BITS  = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [skf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [31:0]                measurement,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [31:0]                estimate,
	output logic [31:0]                covariance
);

	logic [31:0]         process_noise;
	logic [31:0]         measurement_noise;
	logic [31:0]         initial_estimate;
	logic                use_initial_estimate;
	skf_pkg::dp_cmd_t    cmd;
	skf_pkg::dp_status_t status;

	skf_regs u_regs (
		.clk                  (clk),
		.arst_n               (arst_n),
		.psel                 (psel),
		.penable              (penable),
		.pwrite               (pwrite),
		.paddr                (paddr),
		.pwdata               (pwdata),
		.prdata               (prdata),
		.pready               (pready),
		.process_noise        (process_noise),
		.measurement_noise    (measurement_noise),
		.initial_estimate     (initial_estimate),
		.use_initial_estimate (use_initial_estimate)
	);

	skf_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	skf_datapath #(
		.FRAC_BITS  (FRAC_BITS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.process_noise        (process_noise),
		.measurement_noise    (measurement_noise),
		.initial_estimate     (initial_estimate),
		.use_initial_estimate (use_initial_estimate),
		.measurement          (measurement),
		.estimate             (estimate),
		.covariance           (covariance)
	);

endmodule

// ----- hw/rtl/skf_checker.sv -----
// Port-level checks of the scalar Kalman filter, bound to the top level.
module skf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        op,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] estimate,
	input logic [31:0] covariance
);

	// an update request keeps the input stalled for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == skf_pkg::OP_UPDATE |=> in_stall)
		else $error("update request not followed by stall");

	// a restart completes at once
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == skf_pkg::OP_RESTART |=> !in_stall)
		else $error("restart request held the input");

	// a new result only appears when an update was finishing
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an update in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(estimate) && $stable(covariance))
		else $error("stalled result changed");

endmodule

bind scalar_kalman_filter_top skf_checker u_skf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.op         (op),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.estimate   (estimate),
	.covariance (covariance)
);

// ----- tb/scalar_kalman_filter_top_tb.sv -----
// Self-checking testbench for the scalar Kalman filter: APB setup, request stream, result check.
`timescale 1ns / 1ps

module scalar_kalman_filter_top_tb;

	localparam int FRAC          = 16;
	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam int UPDATE_CYCLES = 2 * FRAC + 6;
	localparam int SETTLE_CYCLES = UPDATE_CYCLES + 20;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 54;

	typedef struct packed {
		logic [31:0] est;
		logic [31:0] cov;
	} filter_out_t;

	class kalman_tracker;
		logic [31:0]        q_var;
		logic [31:0]        r_var;
		logic signed [31:0] x0;
		logic               x0_armed;
		logic signed [31:0] cur_est;
		logic [31:0]        cur_var;
		logic               primed;
		filter_out_t        expected_updates[$];
		int                 errors;

		function new();
			q_var    = 32'd655;
			r_var    = ONE;
			x0       = '0;
			x0_armed = 1'b0;
			cur_est  = '0;
			cur_var  = ONE;
			primed   = 1'b0;
			errors   = 0;
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				skf_pkg::REG_PROCESS_NOISE:     q_var = val;
				skf_pkg::REG_MEASUREMENT_NOISE: r_var = val;
				skf_pkg::REG_INITIAL_ESTIMATE:  x0 = val;
				skf_pkg::REG_USE_INITIAL:       x0_armed = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_updates.size();
		endfunction

		// advance the filter by one request and queue the result it gives
		function void take_request(logic o, logic [31:0] m);
			logic [32:0]       p1;
			logic [33:0]       den;
			longint unsigned   num, dv, gain, mag, delta, shrunk;
			longint            innov, next_est;
			if (o == skf_pkg::OP_RESTART) begin
				cur_est = x0;
				cur_var = ONE;
				primed  = x0_armed;
				return;
			end
			if (!primed) begin
				cur_est = m;
				cur_var = ONE;
				primed  = 1'b1;
			end else begin
				p1 = {1'b0, cur_var} + {1'b0, q_var};
				if (p1[32])
					p1 = {1'b0, 32'hFFFF_FFFF};
				den = {1'b0, p1} + {2'b00, r_var};
				num = longint'(p1);
				dv  = longint'(den);
				if (dv == 0)
					gain = longint'(ONE);
				else
					gain = (num << FRAC) / dv;
				if (gain > longint'(ONE))
					gain = longint'(ONE);
				innov = longint'($signed(m)) - longint'(cur_est);
				mag   = (innov < 0) ? longint'(-innov) : longint'(innov);
				delta = (mag * gain) >> FRAC;
				if (innov < 0)
					next_est = longint'(cur_est) - longint'(delta);
				else
					next_est = longint'(cur_est) + longint'(delta);
				cur_est = next_est[31:0];
				shrunk  = (num * (longint'(ONE) - gain)) >> FRAC;
				cur_var = (shrunk > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : shrunk[31:0];
			end
			expected_updates.push_back('{est: cur_est, cov: cur_var});
		endfunction

		task check_result(logic [31:0] est, logic [31:0] cov);
			filter_out_t want;
			if (expected_updates.size() == 0) begin
				report($sformatf("result est=%h cov=%h with none expected", est, cov));
				return;
			end
			want = expected_updates.pop_front();
			if (est !== want.est)
				report($sformatf("estimate %h, expected %h", est, want.est));
			if (cov !== want.cov)
				report($sformatf("covariance %h, expected %h", cov, want.cov));
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [skf_pkg::ADDR_W-1:0]   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         in_valid;
	logic                         in_stall;
	logic                         op;
	logic [31:0]                  measurement;
	logic                         out_valid;
	logic                         out_stall;
	logic [31:0]                  estimate;
	logic [31:0]                  covariance;

	kalman_tracker tracker;
	logic          no_idle;
	logic [31:0]   last_meas;
	int            cycles;

	scalar_kalman_filter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.estimate    (estimate),
		.covariance  (covariance)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// results first: a request taken at this edge cannot complete at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_result(estimate, covariance);
			if (in_valid && !in_stall)
				tracker.take_request(op, measurement);
		end
	end

	// receiver back-pressure in random bursts
	initial begin
		int  span;
		logic hold;
		forever begin
			span = $urandom_range(1, 10);
			hold = !no_idle && ($urandom_range(0, 2) == 0);
			out_stall <= hold;
			repeat (span) @(posedge clk);
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= skf_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_reg(idx, val);
	endtask

	task automatic load_config(input logic [31:0] q, input logic [31:0] r,
			input logic [31:0] x0, input logic armed);
		reg_write(skf_pkg::REG_PROCESS_NOISE, q);
		reg_write(skf_pkg::REG_MEASUREMENT_NOISE, r);
		reg_write(skf_pkg::REG_INITIAL_ESTIMATE, x0);
		reg_write(skf_pkg::REG_USE_INITIAL, {31'b0, armed});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(input logic o, input logic [31:0] m);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= o;
		measurement <= m;
		do @(posedge clk); while (in_stall);
		last_meas = m;
	endtask

	// drop valid, wait for every result, then let a restart finish too
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_noise();
		case ($urandom_range(0, 6))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom_range(0, 2000);
			3:       return $urandom_range(0, 1 << 20);
			4:       return $urandom_range(1 << 16, 1 << 24);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_measurement();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0:       return 32'h7FFF_FFFF;
					1:       return 32'h8000_0000;
					2:       return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3: return $urandom;
			default: return last_meas + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	initial begin
		logic [31:0] x0;
		tracker     = new();
		cycles      = 0;
		no_idle     = 1'b0;
		last_meas   = '0;
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		op          <= skf_pkg::OP_UPDATE;
		measurement <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: seed at the top, swing to the bottom, reseed after restart
		send_request(skf_pkg::OP_UPDATE, 32'h7FFF_FFFF);
		send_request(skf_pkg::OP_UPDATE, 32'h8000_0000);
		send_request(skf_pkg::OP_UPDATE, 32'h0000_0000);
		send_request(skf_pkg::OP_UPDATE, 32'hFFFF_FFFF);
		send_request(skf_pkg::OP_RESTART, 32'h0000_0000);
		send_request(skf_pkg::OP_UPDATE, 32'h1234_5678);
		settle();

		// largest noise: covariance saturates, armed initial estimate at the top
		load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_request(skf_pkg::OP_RESTART, 32'h5555_5555);
		send_request(skf_pkg::OP_UPDATE, 32'h8000_0000);
		send_request(skf_pkg::OP_UPDATE, 32'h7FFF_FFFF);
		settle();

		// no noise: unit gain, then a zero denominator
		load_config(32'h0, 32'h0, 32'h8000_0000, 1'b1);
		send_request(skf_pkg::OP_RESTART, 32'h0);
		send_request(skf_pkg::OP_UPDATE, 32'h7FFF_FFFF);
		send_request(skf_pkg::OP_UPDATE, 32'h0000_0000);
		send_request(skf_pkg::OP_UPDATE, 32'h8000_0000);
		settle();

		// tiny gain, and a restart whose measurement must be ignored
		load_config(32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
		send_request(skf_pkg::OP_RESTART, 32'hFFFF_FFFF);
		send_request(skf_pkg::OP_UPDATE, 32'h0000_0005);
		send_request(skf_pkg::OP_UPDATE, 32'hFFFF_FFFB);
		send_request(skf_pkg::OP_RESTART, 32'hAAAA_AAAA);
		settle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0:       x0 = 32'h7FFF_FFFF;
				1:       x0 = 32'h8000_0000;
				default: x0 = $urandom;
			endcase
			load_config(pick_noise(), pick_noise(), x0, 1'($urandom_range(0, 1)));
			if (ph == RANDOM_PHASES - 1)
				no_idle = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 11) == 0)
					send_request(skf_pkg::OP_RESTART, $urandom);
				else
					send_request(skf_pkg::OP_UPDATE, pick_measurement());
			end
			settle();
		end

		if (tracker.pending() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.pending()));
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
